// ===== sv/ors_pkg.sv =====
// ----------------------------------------------------------------------------
// ors_pkg
// Shared types and constants of the overwriting ring stack: transaction
// payloads, operation codes and the status passed from control to top.
// ----------------------------------------------------------------------------
package ors_pkg;

   // fixed field widths
   localparam int OP_W   = 3;
   localparam int DATA_W = 64;
   localparam int CNT_W  = 7;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_DROP   = 3'd1;
   localparam logic [OP_W-1:0] OP_TOP    = 3'd2;
   localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
   localparam logic [OP_W-1:0] OP_REWIND = 3'd4;

   // capacity after reset
   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   // request transaction
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [DATA_W-1:0] push_data;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              found;
      logic              evicted;
      logic [CNT_W-1:0]  entry_count;
   } rsp_type;

   // result status from control, aligned with the ram read data
   typedef struct packed {
      logic             valid;
      logic             found;
      logic             evicted;
      logic [CNT_W-1:0] entry_count;
   } stat_type;

endpackage

// ===== sv/overwriting_ring_stack.sv =====
// ----------------------------------------------------------------------------
// overwriting_ring_stack
// Bounded LIFO stack kept in a ring of RAM entries; a push onto a full stack
// overwrites and returns the oldest entry, with an iterator from newest down.
//
//   channel   handshake             payload
//   request   start / busy          req_payload  (operation, push_data)
//   result    rsp_strobe            rsp_payload  (read_data, found, evicted,
//                                                 entry_count)
//   csr       csr_wr_en             csr_wr_data  (capacity)
//
// One transaction is taken every cycle in which csr_wr_en is low; busy stays low.
// The result shows for one cycle, in the cycle after acceptance, set by the
// registered read of the entry RAM; pointer updates land at the same clock edge.
// Synchronous reset clears the pointers and sets capacity to 64; RAM
// contents are left as they are, and no clearing pass is needed.
// The receiver cannot stall, so no result is ever held back.
// ----------------------------------------------------------------------------
module overwriting_ring_stack #(
   parameter int DEPTH      = 64,
   parameter int ENTRY_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  ors_pkg::req_type           req_payload,
   output logic                       rsp_strobe,
   output ors_pkg::rsp_type           rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [ors_pkg::CNT_W-1:0]  csr_wr_data
);
   import ors_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic                  ram_we;
   logic                  ram_re;
   logic [ADDR_W-1:0]     ram_addr;
   logic [ENTRY_BITS-1:0] ram_wdata;
   logic [ENTRY_BITS-1:0] ram_rdata;
   stat_type              stat;

   // pointer control
   ors_ctrl #(
      .DEPTH      (DEPTH),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .busy        (busy),
      .ram_we      (ram_we),
      .ram_re      (ram_re),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .stat        (stat)
   );

   // entry store
   ors_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // result transaction
   assign rsp_strobe              = stat.valid;
   assign rsp_payload.read_data   = stat.found ? DATA_W'(ram_rdata) : '0;
   assign rsp_payload.found       = stat.found;
   assign rsp_payload.evicted     = stat.evicted;
   assign rsp_payload.entry_count = stat.entry_count;

endmodule

// ===== sv/ors_ram.sv =====
// ----------------------------------------------------------------------------
// ors_ram
// Generic single-port synchronous RAM, read-first, with registered read data.
// ----------------------------------------------------------------------------
module ors_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old contents when the same entry is written
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ors_ctrl.sv =====
// ----------------------------------------------------------------------------
// ors_ctrl
// Pointer control of the ring stack: capacity register, head, count and
// iterator, ram address generation and the result status register.
// ----------------------------------------------------------------------------
module ors_ctrl #(
   parameter int DEPTH      = 64,
   parameter int ENTRY_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  ors_pkg::req_type           req,
   input  logic                       csr_wr_en,
   input  logic [ors_pkg::CNT_W-1:0]  csr_wr_data,
   output logic                       busy,
   output logic                       ram_we,
   output logic                       ram_re,
   output logic [$clog2(DEPTH)-1:0]   ram_addr,
   output logic [ENTRY_BITS-1:0]      ram_wdata,
   output ors_pkg::stat_type          stat
);
   import ors_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic [CNT_W-1:0] capacity_ff, capacity_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0] iter_ff, iter_in;
   stat_type         stat_ff, stat_in;

   logic             accept;
   logic [CNT_W-1:0] cap;
   logic [CNT_W:0]   head_plus;
   logic [CNT_W-1:0] head_inc;
   logic [CNT_W-1:0] head_dec;
   logic [CNT_W-1:0] held_dec;
   logic [CNT_W-1:0] next_back;
   logic [CNT_W:0]   next_sum;
   logic [CNT_W:0]   next_wrap;
   logic [CNT_W-1:0] next_slot;
   logic [CNT_W-1:0] slot;
   logic             full;

   // one transaction per cycle while csr_wr_en is low, never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // capacity in use: zero acts as one, values above the depth clamp
   assign cap = (capacity_ff == '0) ? CNT_W'(1)
              : (int'(capacity_ff) > DEPTH) ? CNT_W'(DEPTH) : capacity_ff;

   // head neighbors on the ring
   assign head_plus = {1'b0, head_ff} + (CNT_W+1)'(1);
   assign head_inc  = (head_plus >= {1'b0, cap}) ? '0 : head_plus[CNT_W-1:0];
   assign head_dec  = (head_ff == '0) ? cap - CNT_W'(1) : head_ff - CNT_W'(1);
   assign held_dec  = held_ff - CNT_W'(1);
   assign full      = (held_ff == cap);

   // slot of the next iterator entry, counted back from the head
   assign next_back = held_ff - iter_ff + CNT_W'(1);
   assign next_sum  = {1'b0, head_ff} + {1'b0, cap} - {1'b0, next_back};
   assign next_wrap = next_sum - {1'b0, cap};
   assign next_slot = (next_sum >= {1'b0, cap}) ? next_wrap[CNT_W-1:0]
                                                : next_sum[CNT_W-1:0];

   // operation decode and pointer update
   always_comb begin
      capacity_in = capacity_ff;
      head_in     = head_ff;
      held_in     = held_ff;
      iter_in     = iter_ff;
      slot        = head_dec;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      stat_in     = '0;
      if (csr_wr_en) begin
         capacity_in = csr_wr_data;
         head_in     = '0;
         held_in     = '0;
         iter_in     = '0;
      end else if (accept) begin
         stat_in.valid = 1'b1;
         unique case (req.operation)
            OP_PUSH: begin
               slot    = head_ff;
               ram_we  = 1'b1;
               ram_re  = full;
               held_in = full ? held_ff : held_ff + CNT_W'(1);
               head_in = head_inc;
               iter_in = full ? held_ff : held_ff + CNT_W'(1);
               stat_in.found   = full;
               stat_in.evicted = full;
            end
            OP_DROP: begin
               if (held_ff != '0) begin
                  slot    = head_dec;
                  ram_re  = 1'b1;
                  held_in = held_dec;
                  head_in = head_dec;
                  iter_in = (iter_ff > held_dec) ? held_dec : iter_ff;
                  stat_in.found = 1'b1;
               end
            end
            OP_TOP: begin
               if (held_ff != '0) begin
                  slot   = head_dec;
                  ram_re = 1'b1;
                  stat_in.found = 1'b1;
               end
            end
            OP_NEXT: begin
               if (iter_ff != '0) begin
                  slot    = next_slot;
                  ram_re  = 1'b1;
                  iter_in = iter_ff - CNT_W'(1);
                  stat_in.found = 1'b1;
               end
            end
            OP_REWIND: begin
               iter_in = held_ff;
            end
            default: begin
            end
         endcase
         stat_in.entry_count = held_in;
      end
   end

   assign ram_addr  = ADDR_W'(slot);
   assign ram_wdata = req.push_data[ENTRY_BITS-1:0];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         head_ff     <= '0;
         held_ff     <= '0;
         iter_ff     <= '0;
         stat_ff     <= '0;
      end else begin
         capacity_ff <= capacity_in;
         head_ff     <= head_in;
         held_ff     <= held_in;
         iter_ff     <= iter_in;
         stat_ff     <= stat_in;
      end
   end

   assign stat = stat_ff;

`ifndef SYNTH
   // count never exceeds the capacity in use
   a_held_le_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap) else $error("held count above capacity");

   // iterator stays within the held entries
   a_iter_le_held: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= held_ff) else $error("iterator beyond held count");

   // head stays inside the ring
   a_head_lt_cap: assert property (@(posedge clock) disable iff (reset)
      head_ff < cap) else $error("head outside ring");

   // push on a full stack evicts and keeps the count
   a_push_full_evicts: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_wr_en && req.operation == OP_PUSH && full
      |=> stat_ff.evicted && stat_ff.entry_count == $past(held_ff))
      else $error("full push did not evict");
`endif

endmodule
